// ===== rtl/core/ipol_pkg.sv =====
// ----------------------------------------------------------------------------
// ipol_pkg
// Types and constants shared by the IPv4 option list parser and its parts.
// ----------------------------------------------------------------------------
package ipol_pkg;

    localparam logic [5:0] MAX_DATA        = 6'd38;
    localparam logic [5:0] MAX_AREA        = 6'd40;
    localparam logic [5:0] MAX_OPTIONS_RST = 6'd40;

    localparam logic [7:0] OPT_EOL = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;
    localparam logic [7:0] MIN_LEN = 8'd2;

    localparam logic [0:0] REG_MAX_OPTIONS = 1'b0;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_LENGTH = 2'd1;
    localparam logic [1:0] ST_SHORT_LEN = 2'd2;
    localparam logic [1:0] ST_OVERRUN   = 2'd3;

    typedef enum logic [3:0] {
        PH_FIN  = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] option_type;
        logic [7:0] option_length;
        logic [5:0] data_index;
        logic [7:0] data_value;
        logic [5:0] option_count;
        logic [1:0] status;
        logic       last_of_item;
    } t_rec;

    typedef struct packed {
        logic [1:0] num;
        t_rec       rec_a;
        t_rec       rec_b;
    } t_push;

endpackage

// ===== rtl/core/ipol_parse.sv =====
// ----------------------------------------------------------------------------
// ipol_parse
// Option parser state and per-byte decode; emits up to two records per beat.
// ----------------------------------------------------------------------------
module ipol_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte_value,
    input  logic                i_first_byte,
    input  logic [5:0]          i_area_len,
    input  logic [5:0]          i_max_options,
    output ipol_pkg::t_push     o_push
);

    ipol_pkg::t_phase r_phase, n_phase;
    logic [5:0] r_pos, n_pos;
    logic [5:0] r_start, n_start;
    logic [7:0] r_type, n_type;
    logic [7:0] r_len, n_len;
    logic [5:0] r_drx, n_drx;
    logic [5:0] r_found, n_found;
    logic [5:0] r_area, n_area;

    ipol_pkg::t_phase e_phase;
    logic [5:0] e_pos, e_start, e_drx, e_found, e_area, alen_sat;
    logic [7:0] e_type, e_len;
    logic [6:0] pos_inc;
    logic [8:0] opt_end;
    logic       fin, hdr, dat, complete;
    logic [1:0] fin_st;
    logic [7:0] hdr_type, hdr_len;
    ipol_pkg::t_rec rec_end, rec_hdr, rec_dat;

    always_comb begin
        alen_sat = (i_area_len > ipol_pkg::MAX_AREA) ? ipol_pkg::MAX_AREA : i_area_len;
        e_phase  = i_first_byte ? ipol_pkg::PH_TYPE : r_phase;
        e_pos    = i_first_byte ? 6'd0 : r_pos;
        e_start  = i_first_byte ? 6'd0 : r_start;
        e_type   = i_first_byte ? 8'd0 : r_type;
        e_len    = i_first_byte ? 8'd0 : r_len;
        e_drx    = i_first_byte ? 6'd0 : r_drx;
        e_found  = i_first_byte ? 6'd0 : r_found;
        e_area   = i_first_byte ? alen_sat : r_area;
        pos_inc  = {1'b0, e_pos} + 7'd1;
        opt_end  = {3'b000, e_start} + {1'b0, e_len};

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_start  = r_start;
        n_type   = r_type;
        n_len    = r_len;
        n_drx    = r_drx;
        n_found  = r_found;
        n_area   = r_area;
        fin      = 1'b0;
        fin_st   = ipol_pkg::ST_OK;
        hdr      = 1'b0;
        dat      = 1'b0;
        complete = 1'b0;
        hdr_type = 8'd0;
        hdr_len  = 8'd0;

        if (i_accept && (i_first_byte || r_phase != ipol_pkg::PH_FIN)) begin
            n_phase = e_phase;
            n_pos   = e_pos;
            n_start = e_start;
            n_type  = e_type;
            n_len   = e_len;
            n_drx   = e_drx;
            n_found = e_found;
            n_area  = e_area;
            if (i_first_byte && alen_sat == 6'd0) begin
                fin = 1'b1;
            end else begin
                n_pos = pos_inc[5:0];
                case (e_phase)
                    ipol_pkg::PH_TYPE: begin
                        if (e_found >= i_max_options) begin
                            fin = 1'b1;
                        end else begin
                            n_start = e_pos;
                            n_type  = i_byte_value;
                            n_len   = 8'd0;
                            n_drx   = 6'd0;
                            if (i_byte_value == ipol_pkg::OPT_EOL ||
                                i_byte_value == ipol_pkg::OPT_NOP) begin
                                n_found  = e_found + 6'd1;
                                hdr      = 1'b1;
                                hdr_type = i_byte_value;
                                if (i_byte_value == ipol_pkg::OPT_EOL) begin
                                    fin = 1'b1;
                                end else begin
                                    complete = 1'b1;
                                end
                            end else if (pos_inc >= {1'b0, e_area}) begin
                                fin    = 1'b1;
                                fin_st = ipol_pkg::ST_NO_LENGTH;
                            end else begin
                                n_phase = ipol_pkg::PH_LEN;
                            end
                        end
                    end
                    ipol_pkg::PH_LEN: begin
                        n_len = i_byte_value;
                        if (i_byte_value < ipol_pkg::MIN_LEN) begin
                            fin    = 1'b1;
                            fin_st = ipol_pkg::ST_SHORT_LEN;
                        end else if ({3'b000, e_start} + {1'b0, i_byte_value} >
                                     {3'b000, e_area}) begin
                            fin    = 1'b1;
                            fin_st = ipol_pkg::ST_OVERRUN;
                        end else begin
                            n_found  = e_found + 6'd1;
                            hdr      = 1'b1;
                            hdr_type = e_type;
                            hdr_len  = i_byte_value;
                            if (i_byte_value == ipol_pkg::MIN_LEN) begin
                                complete = 1'b1;
                            end else begin
                                n_phase = ipol_pkg::PH_DATA;
                            end
                        end
                    end
                    ipol_pkg::PH_DATA: begin
                        dat   = (e_drx < ipol_pkg::MAX_DATA);
                        n_drx = e_drx + 6'd1;
                        if (opt_end <= {2'b00, pos_inc}) begin
                            complete = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = ipol_pkg::PH_FIN;
                    end
                endcase
                if (complete) begin
                    n_phase = ipol_pkg::PH_TYPE;
                    if (pos_inc >= {1'b0, e_area}) begin
                        fin = 1'b1;
                    end
                end
            end
            if (fin) begin
                n_phase = ipol_pkg::PH_FIN;
            end
        end

        rec_end = '{kind: ipol_pkg::KIND_END, option_type: 8'd0, option_length: 8'd0,
                    data_index: 6'd0, data_value: 8'd0, option_count: n_found,
                    status: fin_st, last_of_item: 1'b1};
        rec_hdr = '{kind: ipol_pkg::KIND_HEADER, option_type: hdr_type,
                    option_length: hdr_len, data_index: 6'd0, data_value: 8'd0,
                    option_count: n_found, status: ipol_pkg::ST_OK, last_of_item: !fin};
        rec_dat = '{kind: ipol_pkg::KIND_DATA, option_type: e_type, option_length: e_len,
                    data_index: e_drx, data_value: i_byte_value, option_count: n_found,
                    status: ipol_pkg::ST_OK, last_of_item: !fin};

        o_push.rec_b = rec_end;
        if (hdr) begin
            o_push.rec_a = rec_hdr;
        end else if (dat) begin
            o_push.rec_a = rec_dat;
        end else begin
            o_push.rec_a = rec_end;
        end
        o_push.num = {1'b0, (hdr || dat || fin)} + {1'b0, ((hdr || dat) && fin)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ipol_pkg::PH_FIN;
            r_pos   <= 6'd0;
            r_start <= 6'd0;
            r_type  <= 8'd0;
            r_len   <= 8'd0;
            r_drx   <= 6'd0;
            r_found <= 6'd0;
            r_area  <= 6'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_type  <= n_type;
            r_len   <= n_len;
            r_drx   <= n_drx;
            r_found <= n_found;
            r_area  <= n_area;
        end
    end

endmodule

// ===== rtl/core/ipol_rec_fifo.sv =====
// ----------------------------------------------------------------------------
// ipol_rec_fifo
// Result record queue; takes up to two records per cycle, gives one per beat.
// ----------------------------------------------------------------------------
module ipol_rec_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ipol_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output ipol_pkg::t_rec   o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ipol_pkg::t_rec r_slot [DEPTH];
    logic [PW-1:0]  r_wr, n_wr, r_rd, n_rd, wr_nx;
    logic [CW-1:0]  r_cnt, n_cnt;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_nx   = wrap_inc(r_wr);
        o_valid = (r_cnt != '0);
        o_room  = (r_cnt <= CW'(DEPTH - 2));
        o_head  = r_slot[r_rd];
        n_rd    = i_pop ? wrap_inc(r_rd) : r_rd;
        case (i_push.num)
            2'd1:    n_wr = wr_nx;
            2'd2:    n_wr = wrap_inc(wr_nx);
            default: n_wr = r_wr;
        endcase
        n_cnt = r_cnt + CW'(i_push.num) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_slot[r_wr] <= i_push.rec_a;
        end
        if (i_push.num == 2'd2) begin
            r_slot[wr_nx] <= i_push.rec_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/ipv4_option_list_parser.sv =====
// Latency: a byte's first record is offered on the cycle after the byte's beat if no earlier record is queued.
// Throughput: one byte per cycle while the queue has room; a byte with two records holds the output for both,
// and a FIFO_DEPTH-entry record queue absorbs that while input keeps flowing.
// Input ready stays high while the queue has room for two records.
// Reset (synchronous, active low) empties the queue, parks the parser until a first
// byte, and sets max_options to 40.
// ----------------------------------------------------------------------------
// ipv4_option_list_parser
// IPv4 options area parser with an APB register for the option limit.
// ----------------------------------------------------------------------------
module ipv4_option_list_parser #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_first_byte,
    input  logic [5:0]  i_area_len,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_option_type,
    output logic [7:0]  o_option_length,
    output logic [5:0]  o_data_index,
    output logic [7:0]  o_data_value,
    output logic [5:0]  o_option_count,
    output logic [1:0]  o_status,
    output logic        o_last_of_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]      r_max_options;
    logic            room;
    ipol_pkg::t_push push;
    ipol_pkg::t_rec  head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ipol_pkg::REG_MAX_OPTIONS) ? {26'd0, r_max_options} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_options <= ipol_pkg::MAX_OPTIONS_RST;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == ipol_pkg::REG_MAX_OPTIONS) begin
            r_max_options <= pwdata[5:0];
        end
    end

    assign o_ready = room;

    ipol_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (i_valid && o_ready),
        .i_byte_value  (i_byte_value),
        .i_first_byte  (i_first_byte),
        .i_area_len    (i_area_len),
        .i_max_options (r_max_options),
        .o_push        (push)
    );

    ipol_rec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_valid && i_ready),
        .o_room  (room),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_kind          = head.kind;
    assign o_option_type   = head.option_type;
    assign o_option_length = head.option_length;
    assign o_data_index    = head.data_index;
    assign o_data_value    = head.data_value;
    assign o_option_count  = head.option_count;
    assign o_status        = head.status;
    assign o_last_of_item  = head.last_of_item;

endmodule

// ===== rtl/core/ipol_checker.sv =====
// ----------------------------------------------------------------------------
// ipol_checker
// Port-level checks on the parser's record stream.
// ----------------------------------------------------------------------------
module ipol_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_option_type,
    input logic [7:0] o_option_length,
    input logic [5:0] o_data_index,
    input logic [7:0] o_data_value,
    input logic [1:0] o_status,
    input logic       o_last_of_item
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_kind) && $stable(o_option_type) &&
            $stable(o_option_length) && $stable(o_data_index) &&
            $stable(o_data_value) && $stable(o_status))
        else $error("output payload changed while stalled");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == ipol_pkg::KIND_END |-> o_last_of_item)
        else $error("end record not last of its byte");

    a_status_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != ipol_pkg::KIND_END |-> o_status == ipol_pkg::ST_OK)
        else $error("error status on a non-end record");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == ipol_pkg::KIND_DATA |-> o_option_length > ipol_pkg::MIN_LEN)
        else $error("data record for an option without data");

endmodule

bind ipv4_option_list_parser ipol_checker u_ipol_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_kind          (o_kind),
    .o_option_type   (o_option_type),
    .o_option_length (o_option_length),
    .o_data_index    (o_data_index),
    .o_data_value    (o_data_value),
    .o_status        (o_status),
    .o_last_of_item  (o_last_of_item)
);
